// ===== hw/rtl/kpdc_pkg.sv =====
package kpdc_pkg;

    localparam int PIN_W      = 6;
    localparam int KEY_IDX_W  = 3;
    localparam int TIMER_W    = 16;
    localparam int OUT_KEYS   = 6;
    localparam int TYPES_W    = 2 * OUT_KEYS;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [TIMER_W-1:0] SHORT_RST = 16'd5;
    localparam logic [TIMER_W-1:0] LONG_RST  = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_TICKS = 1'b0,
        CFG_LONG_TICKS  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        TY_NONE  = 2'd0,
        TY_SHORT = 2'd1,
        TY_LONG  = 2'd2,
        TY_HELD  = 2'd3
    } t_type;

    typedef struct packed {
        logic scan;
        logic clear;
        logic high;
    } t_lane_ctl;

    typedef struct packed {
        logic [TIMER_W-1:0] short_ticks;
        logic [TIMER_W-1:0] long_ticks;
    } t_thresh;

endpackage

// ===== hw/rtl/kpdc_lane.sv =====
module kpdc_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kpdc_pkg::t_thresh   i_thresh,
    input  kpdc_pkg::t_lane_ctl i_ctl,
    output kpdc_pkg::t_type     o_type
);
    import kpdc_pkg::*;

    t_phase             r_phase, n_phase;
    logic [TIMER_W-1:0] r_timer, n_timer;
    t_type              r_type,  n_type;
    t_phase             w_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_type  <= TY_NONE;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_type  <= n_type;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_type  = r_type;
        w_ph    = r_phase;
        if (i_ctl.clear) begin
            n_phase = PH_IDLE;
            n_timer = '0;
            n_type  = TY_NONE;
        end else if (i_ctl.scan) begin
            if (r_phase == PH_IDLE) begin
                if (!i_ctl.high) begin
                    n_phase = PH_PRESSED;
                    n_timer = '0;
                end
            end else begin
                if (i_ctl.high) begin
                    w_ph = (r_phase == PH_PRESSED) ? PH_RELEASED : PH_IDLE;
                end
                n_phase = w_ph;
                case (w_ph)
                    PH_PRESSED: begin
                        if (r_timer != TIMER_MAX) begin
                            n_timer = r_timer + 1'b1;
                        end
                        if (n_timer >= i_thresh.long_ticks) begin
                            n_type = TY_HELD;
                        end
                    end
                    PH_RELEASED: begin
                        if (r_timer >= i_thresh.long_ticks) begin
                            n_type = TY_LONG;
                        end else if (r_timer >= i_thresh.short_ticks) begin
                            n_type = TY_SHORT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_type = r_type;

endmodule

// ===== hw/rtl/kpdc_merge.sv =====
module kpdc_merge #(
    parameter int NUM_KEYS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kpdc_pkg::t_type [NUM_KEYS-1:0] i_types,
    input  logic                           i_push,
    output logic                           o_full,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [kpdc_pkg::TYPES_W-1:0]   o_key_types
);
    import kpdc_pkg::*;

    logic [TYPES_W-1:0] w_packed;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    logic [TYPES_W-1:0] r_out, n_out;
    logic [TYPES_W-1:0] r_skid, n_skid;
    logic               w_take;

    for (genvar k = 0; k < OUT_KEYS; k++) begin : g_pack
        if (k < NUM_KEYS) begin : g_key
            assign w_packed[2*k +: 2] = i_types[k];
        end else begin : g_none
            assign w_packed[2*k +: 2] = TY_NONE;
        end
    end

    // Types are sampled in the cycle after the transaction, once lanes hold the update.
    logic r_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_push       <= i_push;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign w_take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = r_push;
                n_skid       = w_packed;
            end else begin
                n_out_valid = r_push;
                n_out       = w_packed;
            end
        end else if (r_push) begin
            n_skid_valid = 1'b1;
            n_skid       = w_packed;
        end
    end

    // One result in flight between lanes and buffer: stop intake while it could not land.
    assign o_full      = r_skid_valid || (r_push && r_out_valid && i_stall);
    assign o_valid     = r_out_valid;
    assign o_key_types = r_out;

endmodule

// ===== hw/rtl/key_press_duration_classifier.sv =====
// Key press duration classifier: NUM_KEYS active-low buttons, one small phase machine per
// key (idle, pressed, released), each in its own lane, all lanes updated together in the
// cycle a transaction is taken. A scan transaction (func 0) steps every key with its pin
// level; a clear transaction (func 1) resets the key named by key_index. Each transaction
// returns all six 2-bit types (0 none, 1 short, 2 long released, 3 long held) through the
// lanes and the two-entry output buffer. One transaction per cycle is sustained; intake
// stalls only when a result might not fit. Keys above six read as released, not reported.
module key_press_duration_classifier #(
    parameter int NUM_KEYS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kpdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kpdc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [kpdc_pkg::PIN_W-1:0]        i_pin_levels,
    input  logic [kpdc_pkg::KEY_IDX_W-1:0]    i_key_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [kpdc_pkg::TYPES_W-1:0]      o_key_types
);
    import kpdc_pkg::*;

    t_thresh                r_thresh;
    logic                   w_accept;
    logic                   w_full;
    t_type [NUM_KEYS-1:0]   w_types;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.short_ticks <= SHORT_RST;
            r_thresh.long_ticks  <= LONG_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_TICKS: r_thresh.short_ticks <= i_cfg_data;
                CFG_LONG_TICKS:  r_thresh.long_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        t_lane_ctl w_ctl;

        assign w_ctl.scan  = w_accept && !i_func;
        assign w_ctl.clear = w_accept && i_func && (32'(i_key_index) == k);
        if (k < PIN_W) begin : g_pin
            assign w_ctl.high = i_pin_levels[k];
        end else begin : g_nopin
            assign w_ctl.high = 1'b1;
        end

        kpdc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_thresh (r_thresh),
            .i_ctl    (w_ctl),
            .o_type   (w_types[k])
        );
    end

    kpdc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_types     (w_types),
        .i_push      (w_accept),
        .o_full      (w_full),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_key_types (o_key_types)
    );

endmodule
